// ===== sv/mac_header_parse_classify_defines.svh =====
// Assertion macros used by the checker file.
`ifndef MAC_HEADER_PARSE_CLASSIFY_DEFINES_SVH
`define MAC_HEADER_PARSE_CLASSIFY_DEFINES_SVH

// Clocked assertion, ignored while reset is held.
`define MHPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define MHPC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/mhpc_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpc_pkg
// Types and constants of the 802.15.4 MAC header parser and classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhpc_pkg;

    // Input word: one frame byte.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_in_word;

    // Output word: one header record.
    typedef struct packed {
        logic [2:0]  frame_kind;
        logic [7:0]  sequence_number;
        logic [15:0] dest_pan;
        logic [63:0] dest_address;
        logic [3:0]  dest_address_bytes;
        logic [15:0] source_pan;
        logic [63:0] source_address;
        logic [3:0]  source_address_bytes;
        logic [6:0]  header_bytes;
        logic [1:0]  protocol;
        logic [6:0]  frame_bytes;
    } t_out_word;

    // Frame types
    localparam logic [2:0] FT_BEACON  = 3'd0;
    localparam logic [2:0] FT_DATA    = 3'd1;
    localparam logic [2:0] FT_ACK     = 3'd2;
    localparam logic [2:0] FT_COMMAND = 3'd3;

    // Address modes
    localparam logic [1:0] AM_NONE     = 2'd0;
    localparam logic [1:0] AM_RESERVED = 2'd1;
    localparam logic [1:0] AM_SHORT    = 2'd2;
    localparam logic [1:0] AM_LONG     = 2'd3;

    // Protocol codes
    localparam logic [1:0] PROTO_UNKNOWN = 2'd0;
    localparam logic [1:0] PROTO_ZIGBEE  = 2'd1;
    localparam logic [1:0] PROTO_THREAD  = 2'd2;

    // Frame control bit positions
    localparam int FC_SEC_BIT   = 3;
    localparam int FC_PANC_BIT  = 6;
    localparam int FC_DMODE_LSB = 10;
    localparam int FC_VER_LSB   = 12;
    localparam int FC_SMODE_LSB = 14;

    // First payload byte patterns
    localparam logic [7:0] PF_MASK_E0  = 8'hE0;
    localparam logic [7:0] PF_VAL_60   = 8'h60;
    localparam logic [7:0] PF_MASK_C0  = 8'hC0;
    localparam logic [7:0] PF_VAL_80   = 8'h80;
    localparam logic [7:0] PF_MASK_F8  = 8'hF8;
    localparam logic [7:0] PF_VAL_C0   = 8'hC0;
    localparam logic [7:0] PF_VAL_E0   = 8'hE0;
    localparam logic [7:0] PF_MASK_3C  = 8'h3C;
    localparam logic [7:0] PF_VAL_08   = 8'h08;
    localparam logic [7:0] PF_VAL_0C   = 8'h0C;

    // Header bytes of an acknowledgement
    localparam logic [6:0] ACK_HDR_BYTES = 7'd3;

    // Address length in bytes for an address mode
    function automatic logic [3:0] addr_len(input logic [1:0] mode);
        logic [3:0] len;
        unique case (mode)
            AM_SHORT: len = 4'd2;
            AM_LONG:  len = 4'd8;
            default:  len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== sv/mac_header_parse_classify.sv =====
// ----------------------------------------------------------------------------
// mac_header_parse_classify
// 802.15.4 MAC header field extraction and Zigbee/Thread classification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Takes a MAC frame (no PHY length byte) one byte per input word and sustains
// one word per clock cycle while no final byte waits on the output. Each byte
// goes through an input register, then a single pass of capture logic updates
// the field registers; on the byte flagged last, the header record is built
// from the updated fields and loaded into the output register as that byte
// leaves the input register, once no previous record waits on the output.
// The input side keeps taking non-final bytes while a record waits on the
// output; only a final byte waits for the output register to free. Bytes after
// the MAX_FRAME_BYTES-th are dropped, but a last flag among them still closes
// the frame. Fields that were cut short read zero, with header_bytes zero and
// protocol unknown.
module mac_header_parse_classify #(
    parameter int MAX_FRAME_BYTES = 127
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mhpc_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mhpc_pkg::t_out_word  o_out_word
);
    import mhpc_pkg::*;

    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int LW = (PW > 7) ? PW + 1 : 8;
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_FRAME_BYTES);

    // Input stage
    logic      r_in_valid;
    t_in_word  r_in;
    logic      advance;

    // Frame state
    logic [PW-1:0] r_pos,       n_pos;
    logic [15:0]   r_cw,        n_cw;
    logic [7:0]    r_seq,       n_seq;
    logic [15:0]   r_dpan,      n_dpan;
    logic [63:0]   r_daddr,     n_daddr;
    logic [15:0]   r_span,      n_span;
    logic [63:0]   r_saddr,     n_saddr;
    logic [7:0]    r_pf,        n_pf;

    // Output stage
    logic      r_out_valid;
    t_out_word r_out;
    t_out_word n_rec;

    // Field layout from the stored control word
    logic [1:0] cap_dmode, cap_smode;
    logic [4:0] b1, b2, b3, b4;
    logic [LW-1:0] p_ext;

    assign advance    = r_in_valid && (!r_in.last_byte || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    // Region boundaries of the address fields
    always_comb begin
        cap_dmode = r_cw[FC_DMODE_LSB +: 2];
        cap_smode = r_cw[FC_SMODE_LSB +: 2];
        b1 = 5'd3 + ((cap_dmode != AM_NONE) ? 5'd2 : 5'd0);
        b2 = b1 + {1'b0, addr_len(cap_dmode)};
        b3 = b2 + (((cap_smode != AM_NONE) && !r_cw[FC_PANC_BIT]) ? 5'd2 : 5'd0);
        b4 = b3 + {1'b0, addr_len(cap_smode)};
        p_ext = LW'(r_pos);
    end

    // Byte capture by position
    always_comb begin
        logic [2:0] idx;
        logic [0:0] pidx;
        n_pos   = r_pos;
        n_cw    = r_cw;
        n_seq   = r_seq;
        n_dpan  = r_dpan;
        n_daddr = r_daddr;
        n_span  = r_span;
        n_saddr = r_saddr;
        n_pf    = r_pf;
        idx     = '0;
        pidx    = '0;
        if (r_pos < POS_MAX) begin
            n_pos = r_pos + PW'(1);
            if (r_pos == PW'(0)) begin
                n_cw[7:0] = r_in.frame_byte;
            end else if (r_pos == PW'(1)) begin
                n_cw[15:8] = r_in.frame_byte;
            end else if (r_pos == PW'(2)) begin
                n_seq = r_in.frame_byte;
            end else if (r_cw[2:0] != FT_ACK) begin
                if (p_ext < LW'(b1)) begin
                    pidx = ~r_pos[0];
                    n_dpan[pidx*8 +: 8] = r_in.frame_byte;
                end else if (p_ext < LW'(b2)) begin
                    idx = r_pos[2:0] - b1[2:0];
                    n_daddr[idx*8 +: 8] = r_in.frame_byte;
                end else if (p_ext < LW'(b3)) begin
                    pidx = r_pos[0] ^ b2[0];
                    n_span[pidx*8 +: 8] = r_in.frame_byte;
                end else if (p_ext < LW'(b4)) begin
                    idx = r_pos[2:0] - b3[2:0];
                    n_saddr[idx*8 +: 8] = r_in.frame_byte;
                end else if (p_ext == LW'(b4)) begin
                    n_pf = r_in.frame_byte;
                end
            end
        end
    end

    // Header record from the updated state
    always_comb begin
        logic [LW-1:0] len;
        logic [LW-1:0] pos;
        logic [LW-1:0] n;
        logic [1:0]    dmode, smode, ver;
        logic          sec, ok;
        n_rec = '0;
        len   = LW'(n_pos);
        dmode = n_cw[FC_DMODE_LSB +: 2];
        smode = n_cw[FC_SMODE_LSB +: 2];
        ver   = n_cw[FC_VER_LSB +: 2];
        sec   = n_cw[FC_SEC_BIT];
        pos   = LW'(3);
        n     = '0;
        ok    = 1'b0;
        n_rec.frame_bytes = len[6:0];
        if (len >= LW'(2)) begin
            n_rec.frame_kind = n_cw[2:0];
            if (n_cw[2:0] == FT_ACK) begin
                if (len >= LW'(3)) begin
                    n_rec.sequence_number = n_seq;
                    n_rec.header_bytes    = ACK_HDR_BYTES;
                    n_rec.protocol        = ver[1] ? PROTO_THREAD : PROTO_ZIGBEE;
                end
            end else if (len >= LW'(3)) begin
                n_rec.sequence_number = n_seq;
                ok = 1'b1;
            end
        end
        // Destination fields
        if (ok && (dmode != AM_NONE)) begin
            if (pos + LW'(2) > len) begin
                ok = 1'b0;
            end else begin
                n_rec.dest_pan = n_dpan;
                pos = pos + LW'(2);
                n = LW'(addr_len(dmode));
                if (n != '0) begin
                    if (pos + n > len) begin
                        ok = 1'b0;
                    end else begin
                        n_rec.dest_address       = n_daddr;
                        n_rec.dest_address_bytes = addr_len(dmode);
                        pos = pos + n;
                    end
                end
            end
        end
        // Source fields
        if (ok && (smode != AM_NONE)) begin
            if (n_cw[FC_PANC_BIT]) begin
                n_rec.source_pan = n_rec.dest_pan;
            end else if (pos + LW'(2) > len) begin
                ok = 1'b0;
            end else begin
                n_rec.source_pan = n_span;
                pos = pos + LW'(2);
            end
            n = LW'(addr_len(smode));
            if (ok && (n != '0)) begin
                if (pos + n > len) begin
                    ok = 1'b0;
                end else begin
                    n_rec.source_address       = n_saddr;
                    n_rec.source_address_bytes = addr_len(smode);
                    pos = pos + n;
                end
            end
        end
        // Classification on the first payload byte
        if (ok) begin
            n_rec.header_bytes = pos[6:0];
            if (pos < len) begin
                case (n_cw[2:0])
                    FT_BEACON: begin
                        if (pos + LW'(4) < len) n_rec.protocol = PROTO_ZIGBEE;
                    end
                    FT_DATA: begin
                        if (sec && ver[1]) begin
                            n_rec.protocol = PROTO_THREAD;
                        end else if ((n_pf & PF_MASK_E0) == PF_VAL_60) begin
                            n_rec.protocol = PROTO_THREAD;
                        end else if ((n_pf & PF_MASK_C0) == PF_VAL_80) begin
                            n_rec.protocol = PROTO_THREAD;
                        end else if (((n_pf & PF_MASK_F8) == PF_VAL_C0) ||
                                     ((n_pf & PF_MASK_F8) == PF_VAL_E0)) begin
                            n_rec.protocol = PROTO_THREAD;
                        end else if (((n_pf & PF_MASK_3C) == PF_VAL_08) ||
                                     ((n_pf & PF_MASK_3C) == PF_VAL_0C)) begin
                            n_rec.protocol = PROTO_ZIGBEE;
                        end else if (sec) begin
                            n_rec.protocol = PROTO_ZIGBEE;
                        end
                    end
                    FT_COMMAND: begin
                        n_rec.protocol = ver[1] ? PROTO_THREAD : PROTO_ZIGBEE;
                    end
                    default: begin
                        n_rec.protocol = PROTO_UNKNOWN;
                    end
                endcase
            end
        end
    end

    // Frame state registers, cleared at the end of each frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_cw    <= '0;
            r_seq   <= '0;
            r_dpan  <= '0;
            r_daddr <= '0;
            r_span  <= '0;
            r_saddr <= '0;
            r_pf    <= '0;
        end else if (advance) begin
            if (r_in.last_byte) begin
                r_pos   <= '0;
                r_cw    <= '0;
                r_seq   <= '0;
                r_dpan  <= '0;
                r_daddr <= '0;
                r_span  <= '0;
                r_saddr <= '0;
                r_pf    <= '0;
            end else begin
                r_pos   <= n_pos;
                r_cw    <= n_cw;
                r_seq   <= n_seq;
                r_dpan  <= n_dpan;
                r_daddr <= n_daddr;
                r_span  <= n_span;
                r_saddr <= n_saddr;
                r_pf    <= n_pf;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in.last_byte) begin
            r_out <= n_rec;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ===== sv/mhpc_checker.sv =====
// ----------------------------------------------------------------------------
// mhpc_checker
// Port-level checks for the MAC header parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mac_header_parse_classify_defines.svh"

module mhpc_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input mhpc_pkg::t_out_word  o_out_word
);
    import mhpc_pkg::*;

    // No record comes out of reset
    `MHPC_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid, "record after reset")

    // A stalled record holds
    `MHPC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word), "stalled record changed")

    // A parsed header never runs past the frame
    `MHPC_ASSERT(a_hdr_in_frame, i_clk, i_rst_n, o_out_valid |-> o_out_word.header_bytes <= o_out_word.frame_bytes, "header longer than frame")

    // A header cut short is never classified
    `MHPC_ASSERT(a_cut_unknown, i_clk, i_rst_n, o_out_valid && o_out_word.header_bytes == 7'd0 |-> o_out_word.protocol == PROTO_UNKNOWN, "cut header classified")

    // Source address length is 0, 2 or 8 bytes
    `MHPC_ASSERT(a_saddr_len, i_clk, i_rst_n, o_out_valid |-> o_out_word.source_address_bytes == 4'd0 || o_out_word.source_address_bytes == 4'd2 || o_out_word.source_address_bytes == 4'd8, "bad source address length")

endmodule

bind mac_header_parse_classify mhpc_checker u_mhpc_checker (.*);
